// File: rtl/core/multilevel_feedback_thread_scheduler_assert.svh
// assertion macros shared by the scheduler rtl
// no dependencies; included by files that carry concurrent checks
`ifndef MULTILEVEL_FEEDBACK_THREAD_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_THREAD_SCHEDULER_ASSERT_SVH

// property must hold at every clock edge outside reset
`define MFTS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// expression must never be true outside reset
`define MFTS_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  `MFTS_ASSERT(lbl, clk, rstn, !(expr), msg)

`endif

// File: rtl/core/mfts_pkg.sv
// shared types, codes and constants of the thread scheduler
// no dependencies; used by the scheduler top and mfts_queue in rtl/core
`timescale 1ns / 1ps
`default_nettype none

package mfts_pkg;

  // field widths
  localparam int unsigned TID_W     = 4;
  localparam int unsigned LVL_W     = 2;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_CFG   = 8;
  localparam int unsigned TICK_W    = 32;

  // number of ready levels (fixed) and default thread count
  localparam int unsigned LEVELS      = 4;
  localparam int unsigned THREADS_DEF = 16;

  // event kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 3'd0,
    KIND_START = 3'd1,
    KIND_YIELD = 3'd2,
    KIND_BLOCK = 3'd3,
    KIND_EXIT  = 3'd4
  } kind_e;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND0   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND1   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND2   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 3'd7;

  // register reset values, index 0 rightmost
  localparam logic [NUM_CFG-1:0][CFG_W-1:0] CFG_RESET = {
    8'd160, 8'd144, 8'd120, 8'd80, 8'd8, 8'd4, 8'd2, 8'd1
  };

  // request from the sequencer to the ready queues
  typedef struct packed {
    logic             push;
    logic [LVL_W-1:0] push_lvl;
    logic [TID_W-1:0] push_id;
    logic             pick;
    logic [LVL_W-1:0] pick_start;
  } queue_req_t;

  // answer of the ready queues in the same cycle
  typedef struct packed {
    logic push_full;
    logic found;
  } queue_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/multilevel_feedback_thread_scheduler.sv
// Result: the accept edge enters the finish state; the result is registered at the finish edge.
// Items do not overlap: the finish step uses the registered read data of the ready store.
// A waiting result stalls the finish step; a new item is taken once the finish is done.
// Reset: asynchronous, active low; clears timer, queues, levels and registers at once.
// The ready store is left uninitialized and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "multilevel_feedback_thread_scheduler_assert.svh"

// top level: event sequencer, timer, thread levels, configuration
// depends on mfts_pkg and mfts_queue
module multilevel_feedback_thread_scheduler #(
  parameter int unsigned THREADS = mfts_pkg::THREADS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [mfts_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [mfts_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [mfts_pkg::KIND_W-1:0]      in_kind_i,
  input  wire logic [mfts_pkg::TID_W-1:0]       in_thread_id_i,
  input  wire logic                             in_new_thread_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [mfts_pkg::TID_W-1:0]            out_running_id_o,
  output logic                                  out_idle_running_o,
  output logic                                  out_switched_o,
  output logic [mfts_pkg::LVL_W-1:0]            out_slice_level_o,
  output logic                                  out_queue_full_o
);

  localparam int unsigned TID_W     = mfts_pkg::TID_W;
  localparam int unsigned LVL_W     = mfts_pkg::LVL_W;
  localparam int unsigned CFG_W     = mfts_pkg::CFG_W;
  localparam int unsigned NUM_CFG   = mfts_pkg::NUM_CFG;
  localparam int unsigned TICK_W    = mfts_pkg::TICK_W;
  localparam int unsigned TLW       = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(mfts_pkg::LEVELS - 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_FIN  = 2'b10
  } state_e;

  state_e state_q;

  logic [CFG_W-1:0]  cfg_q [NUM_CFG];
  logic [TICK_W-1:0] tick_q;
  logic [TICK_W-1:0] expire_q;
  logic [CFG_W-1:0]  phase_q;
  logic [TID_W-1:0]  cur_q;
  logic              idle_q;
  logic [LVL_W-1:0]  last_q;
  logic [LVL_W-1:0]  tlev_q [THREADS];

  // per-item results kept between accept and finish
  logic              picked_q;
  logic              found_q;
  logic              full_q;
  logic [LVL_W-1:0]  plev_q;

  logic              out_valid_q;
  logic [TID_W-1:0]  out_id_q;
  logic              out_idle_q;
  logic              out_sw_q;
  logic [LVL_W-1:0]  out_slice_q;
  logic              out_full_q;

  logic              accept;
  logic              is_tick;
  logic              is_start;
  logic              is_yield;
  logic              is_stop;
  logic [TICK_W-1:0] tc;
  logic [TICK_W-1:0] diff;
  logic [CFG_W-1:0]  phase_inc;
  logic [CFG_W-1:0]  ph;
  logic [LVL_W-1:0]  plev;
  logic              sched;
  logic              requeue;
  logic [TLW-1:0]    cur_idx;
  logic [TLW-1:0]    tid_idx;
  logic [LVL_W-1:0]  lvl_cur;
  logic              demote;
  logic [LVL_W-1:0]  lvl_new;
  logic              tid_ok;
  logic              st;
  logic [LVL_W-1:0]  lvl_tid;

  mfts_pkg::queue_req_t qreq;
  mfts_pkg::queue_sts_t qsts;
  logic [TID_W-1:0]     pop_id;

  logic              fin_go;
  logic              new_idle;
  logic [TID_W-1:0]  new_cur;
  logic [CFG_W-1:0]  quantum;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  // event decode
  always_comb begin
    is_tick  = 1'b0;
    is_start = 1'b0;
    is_yield = 1'b0;
    is_stop  = 1'b0;
    case (in_kind_i)
      mfts_pkg::KIND_TICK:  is_tick  = 1'b1;
      mfts_pkg::KIND_START: is_start = 1'b1;
      mfts_pkg::KIND_YIELD: is_yield = 1'b1;
      mfts_pkg::KIND_BLOCK: is_stop  = 1'b1;
      mfts_pkg::KIND_EXIT:  is_stop  = 1'b1;
      default: ;
    endcase
  end

  // timer and phase advance on tick
  always_comb begin
    tc        = is_tick ? tick_q + 1'b1 : tick_q;
    diff      = tc - expire_q;
    phase_inc = phase_q + 1'b1;
    ph        = is_tick ? ((phase_inc >= cfg_q[mfts_pkg::CFG_PERIOD]) ? '0 : phase_inc)
                        : phase_q;
  end

  // start level from the phase
  always_comb begin
    if (ph < cfg_q[mfts_pkg::CFG_BOUND0]) begin
      plev = LVL_W'(0);
    end else if (ph < cfg_q[mfts_pkg::CFG_BOUND1]) begin
      plev = LVL_W'(1);
    end else if (ph < cfg_q[mfts_pkg::CFG_BOUND2]) begin
      plev = LVL_W'(2);
    end else begin
      plev = LVL_LAST;
    end
  end

  // scheduling point, demotion and start path
  always_comb begin
    sched   = accept && ((is_tick && !diff[TICK_W-1]) || is_yield || is_stop);
    requeue = is_tick || is_yield;
    cur_idx = TLW'(cur_q);
    tid_idx = TLW'(in_thread_id_i);
    lvl_cur = tlev_q[cur_idx];
    demote  = sched && !idle_q && (tc == expire_q) && (lvl_cur != LVL_LAST);
    lvl_new = demote ? lvl_cur + 1'b1 : lvl_cur;
    tid_ok  = ({5'd0, in_thread_id_i} < 9'(THREADS));
    st      = accept && is_start && tid_ok;
    lvl_tid = in_new_thread_i ? '0 : tlev_q[tid_idx];
  end

  // queue request
  always_comb begin
    qreq.push       = (sched && requeue && !idle_q) || st;
    qreq.push_lvl   = st ? lvl_tid : lvl_new;
    qreq.push_id    = st ? in_thread_id_i : cur_q;
    qreq.pick       = sched;
    qreq.pick_start = plev;
  end

  mfts_queue #(
    .THREADS (THREADS)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (qreq),
    .sts_o    (qsts),
    .pop_id_o (pop_id)
  );

  // finish step: commit the pick and build the result
  always_comb begin
    fin_go   = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);
    new_idle = picked_q ? !found_q : idle_q;
    new_cur  = (picked_q && found_q) ? pop_id : cur_q;
    quantum  = cfg_q[mfts_pkg::CFG_QUANTUM0 + {1'b0, plev_q}];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: if (accept) state_q <= ST_FIN;
        ST_FIN:  if (fin_go) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CFG; i++) begin
        cfg_q[i] <= mfts_pkg::CFG_RESET[i];
      end
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // thread levels
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < THREADS; i++) begin
        tlev_q[i] <= '0;
      end
    end else begin
      if (demote) begin
        tlev_q[cur_idx] <= lvl_new;
      end
      if (st && in_new_thread_i) begin
        tlev_q[tid_idx] <= '0;
      end
    end
  end

  // scheduler state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= '0;
      phase_q  <= '0;
      expire_q <= '0;
      cur_q    <= '0;
      idle_q   <= 1'b1;
      last_q   <= '0;
      picked_q <= 1'b0;
      found_q  <= 1'b0;
      full_q   <= 1'b0;
      plev_q   <= '0;
    end else begin
      if (accept) begin
        tick_q   <= tc;
        phase_q  <= ph;
        picked_q <= sched && !qsts.push_full;
        found_q  <= qsts.found;
        full_q   <= qsts.push_full;
        plev_q   <= plev;
      end
      if (fin_go) begin
        idle_q <= new_idle;
        cur_q  <= new_cur;
        if (picked_q) begin
          expire_q <= tick_q + TICK_W'(quantum);
          last_q   <= plev_q;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      out_id_q    <= new_idle ? '0 : new_cur;
      out_idle_q  <= new_idle;
      out_sw_q    <= (idle_q != new_idle) || (!new_idle && (cur_q != new_cur));
      out_slice_q <= picked_q ? plev_q : last_q;
      out_full_q  <= full_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_running_id_o   = out_id_q;
  assign out_idle_running_o = out_idle_q;
  assign out_switched_o     = out_sw_q;
  assign out_slice_level_o  = out_slice_q;
  assign out_queue_full_o   = out_full_q;

  // checks
  `MFTS_ASSERT(a_out_after_fin, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == ST_FIN),
    "result raised without a finish step")
  `MFTS_ASSERT(a_refused_no_pick, clk_i, rst_ni, (accept && qsts.push_full) |=> !picked_q,
    "pick committed after a refused enqueue")
  `MFTS_ASSERT(a_idle_id_zero, clk_i, rst_ni, (out_valid_q && out_idle_q) |-> (out_id_q == '0),
    "running id not zero while idle runs")

endmodule

`default_nettype wire

// File: rtl/core/mfts_ready_mem.sv
// ready store: one write port, one read port with registered read data
// no dependencies; instantiated by mfts_queue
`timescale 1ns / 1ps
`default_nettype none

module mfts_ready_mem #(
  parameter int unsigned AW = 6,
  parameter int unsigned DW = 4
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/mfts_queue.sv
// four fifo ready levels: pointers, counts, level search, ready store
// depends on mfts_pkg and mfts_ready_mem
`timescale 1ns / 1ps
`default_nettype none
`include "multilevel_feedback_thread_scheduler_assert.svh"

module mfts_queue #(
  parameter int unsigned THREADS = mfts_pkg::THREADS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire mfts_pkg::queue_req_t      req_i,
  output mfts_pkg::queue_sts_t           sts_o,
  output logic [mfts_pkg::TID_W-1:0]     pop_id_o
);

  localparam int unsigned LEVELS = mfts_pkg::LEVELS;
  localparam int unsigned LVL_W  = mfts_pkg::LVL_W;
  localparam int unsigned TID_W  = mfts_pkg::TID_W;
  localparam int unsigned PW     = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int unsigned CW     = $clog2(THREADS + 1);
  localparam int unsigned AW     = LVL_W + PW;
  localparam logic [PW-1:0] PTR_LAST = PW'(THREADS - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(THREADS);

  logic [PW-1:0] head_q  [LEVELS];
  logic [PW-1:0] head_d  [LEVELS];
  logic [PW-1:0] tail_q  [LEVELS];
  logic [PW-1:0] tail_d  [LEVELS];
  logic [CW-1:0] count_q [LEVELS];
  logic [CW-1:0] count_d [LEVELS];

  logic [LEVELS-1:0] nonempty;
  logic              push_full;
  logic              push_ok;
  logic              pick_ok;
  logic              found;
  logic [LVL_W-1:0]  pop_lvl;
  logic              pop_en;
  logic              fwd_d;
  logic              fwd_q;
  logic [TID_W-1:0]  fwd_id_q;
  logic [TID_W-1:0]  rdata;

  // room check; a refused push also cancels the pick
  always_comb begin
    push_full = req_i.push && (count_q[req_i.push_lvl] == CNT_FULL);
    push_ok   = req_i.push && !push_full;
    pick_ok   = req_i.pick && !push_full;
  end

  // occupancy including this cycle's push
  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      nonempty[l] = (count_q[l] != '0) ||
                    (push_ok && (req_i.push_lvl == LVL_W'(l)));
    end
  end

  // first non-empty level going round from the start level
  always_comb begin
    logic [LVL_W-1:0] cand;
    found   = 1'b0;
    pop_lvl = req_i.pick_start;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      cand = req_i.pick_start + LVL_W'(i);
      if (nonempty[cand]) begin
        found   = 1'b1;
        pop_lvl = cand;
      end
    end
  end

  assign pop_en = pick_ok && found;

  // popping the entry written in the same cycle takes the write data
  assign fwd_d = pop_en && push_ok && (pop_lvl == req_i.push_lvl) &&
                 (count_q[pop_lvl] == '0);

  // pointer and count updates
  always_comb begin
    logic inc;
    logic dec;
    for (int l = 0; l < LEVELS; l++) begin
      inc        = push_ok && (req_i.push_lvl == LVL_W'(l));
      dec        = pop_en && (pop_lvl == LVL_W'(l));
      count_d[l] = count_q[l] + CW'(inc) - CW'(dec);
      tail_d[l]  = tail_q[l];
      head_d[l]  = head_q[l];
      if (inc) begin
        tail_d[l] = (tail_q[l] == PTR_LAST) ? '0 : tail_q[l] + 1'b1;
      end
      if (dec) begin
        head_d[l] = (head_q[l] == PTR_LAST) ? '0 : head_q[l] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < LEVELS; l++) begin
        head_q[l]  <= '0;
        tail_q[l]  <= '0;
        count_q[l] <= '0;
      end
      fwd_q <= 1'b0;
    end else begin
      for (int l = 0; l < LEVELS; l++) begin
        head_q[l]  <= head_d[l];
        tail_q[l]  <= tail_d[l];
        count_q[l] <= count_d[l];
      end
      if (pop_en) begin
        fwd_q <= fwd_d;
      end
    end
  end

  // forwarded id, held with the read data
  always_ff @(posedge clk_i) begin
    if (pop_en) begin
      fwd_id_q <= req_i.push_id;
    end
  end

  mfts_ready_mem #(
    .AW (AW),
    .DW (TID_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (push_ok),
    .waddr_i ({req_i.push_lvl, tail_q[req_i.push_lvl]}),
    .wdata_i (req_i.push_id),
    .re_i    (pop_en),
    .raddr_i ({pop_lvl, head_q[pop_lvl]}),
    .rdata_o (rdata)
  );

  assign pop_id_o        = fwd_q ? fwd_id_q : rdata;
  assign sts_o.push_full = push_full;
  assign sts_o.found     = pop_en;

  // checks
  `MFTS_ASSERT(a_pop_has_entry, clk_i, rst_ni, pop_en |-> (count_q[pop_lvl] != '0) || fwd_d,
    "pop from an empty level")
  for (genvar g = 0; g < LEVELS; g++) begin : g_chk
    `MFTS_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q[g] > CNT_FULL,
      "ready level count above capacity")
    `MFTS_ASSERT(a_empty_ptrs, clk_i, rst_ni, (count_q[g] == '0) |-> (head_q[g] == tail_q[g]),
      "empty ready level with unequal pointers")
  end

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for multilevel_feedback_thread_scheduler: directed and random events
// depends on mfts_pkg and the scheduler rtl; predicts each result with an inline scheduler model

module testbench;

  localparam int unsigned TID_W     = mfts_pkg::TID_W;
  localparam int unsigned LVL_W     = mfts_pkg::LVL_W;
  localparam int unsigned CFG_W     = mfts_pkg::CFG_W;
  localparam int unsigned CFG_IDX_W = mfts_pkg::CFG_IDX_W;
  localparam int unsigned NUM_CFG   = mfts_pkg::NUM_CFG;
  localparam int unsigned TICK_W    = mfts_pkg::TICK_W;
  localparam int unsigned LEVELS    = mfts_pkg::LEVELS;

  localparam int unsigned NTHR         = 16;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_WAIT     = 16;
  localparam int unsigned BURST_LEN    = NTHR + 1;

  typedef struct {
    mfts_pkg::kind_e  kind;
    logic [TID_W-1:0] tid;
    logic             fresh;
  } sched_event_t;

  typedef struct {
    logic [TID_W-1:0] running_id;
    logic             idle;
    logic             switched;
    logic [LVL_W-1:0] level;
    logic             full;
  } sched_result_t;

  typedef logic [CFG_W-1:0] reg_set_t [NUM_CFG];

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  // block ports
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  mfts_pkg::kind_e      in_kind = mfts_pkg::KIND_TICK;
  logic [TID_W-1:0]     in_tid = '0;
  logic                 in_fresh = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [TID_W-1:0]     out_running_id;
  logic                 out_idle_running;
  logic                 out_switched;
  logic [LVL_W-1:0]     out_slice_level;
  logic                 out_queue_full;

  multilevel_feedback_thread_scheduler #(
    .THREADS(NTHR)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .in_kind_i         (in_kind),
    .in_thread_id_i    (in_tid),
    .in_new_thread_i   (in_fresh),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .out_running_id_o  (out_running_id),
    .out_idle_running_o(out_idle_running),
    .out_switched_o    (out_switched),
    .out_slice_level_o (out_slice_level),
    .out_queue_full_o  (out_queue_full)
  );

  // scheduler state as predicted
  logic [CFG_W-1:0]  regs [NUM_CFG];
  logic [TICK_W-1:0] ticks;
  logic [TICK_W-1:0] deadline;
  logic [7:0]        phase_ctr;
  logic [TID_W-1:0]  cur_tid;
  logic              cpu_idle;
  logic [LVL_W-1:0]  prio [NTHR];
  logic [TID_W-1:0]  ring [LEVELS][NTHR];
  logic [TID_W-1:0]  rd_ptr [LEVELS];
  logic [TID_W-1:0]  wr_ptr [LEVELS];
  int unsigned       depth_q [LEVELS];
  logic [LVL_W-1:0]  start_lvl;

  // items waiting to be sent and results waiting to arrive
  sched_event_t  pending_events [$];
  sched_result_t expected_results [$];
  sched_event_t  cur_event;

  // handshake bookkeeping and run statistics
  logic        in_taken = 1'b0;
  logic        out_taken = 1'b0;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  int unsigned sent_count = 0;
  int unsigned recv_count = 0;
  bit          calm_send = 1'b0;
  bit          calm_recv = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned n_errors = 0;
  int unsigned n_results = 0;
  int unsigned n_refused = 0;
  int unsigned n_switches = 0;
  int unsigned n_settings = 0;

  function automatic void reset_predictor();
    for (int i = 0; i < NUM_CFG; i++) regs[i] = mfts_pkg::CFG_RESET[i];
    ticks     = '0;
    deadline  = '0;
    phase_ctr = '0;
    cur_tid   = '0;
    cpu_idle  = 1'b1;
    start_lvl = '0;
    for (int t = 0; t < NTHR; t++) prio[t] = '0;
    for (int l = 0; l < LEVELS; l++) begin
      rd_ptr[l]  = '0;
      wr_ptr[l]  = '0;
      depth_q[l] = 0;
    end
  endfunction

  function automatic bit ready_push(int unsigned lvl, logic [TID_W-1:0] id);
    if (depth_q[lvl] >= NTHR) return 1'b0;
    ring[lvl][wr_ptr[lvl]] = id;
    wr_ptr[lvl] = wr_ptr[lvl] + 1'b1;
    depth_q[lvl]++;
    return 1'b1;
  endfunction

  function automatic logic [TID_W-1:0] ready_pop(int unsigned lvl);
    logic [TID_W-1:0] id;
    id = ring[lvl][rd_ptr[lvl]];
    rd_ptr[lvl] = rd_ptr[lvl] + 1'b1;
    depth_q[lvl]--;
    return id;
  endfunction

  // start level from the phase counter and the three bounds
  function automatic logic [LVL_W-1:0] slice_for_phase();
    if (phase_ctr < regs[mfts_pkg::CFG_BOUND0]) return 2'd0;
    if (phase_ctr < regs[mfts_pkg::CFG_BOUND1]) return 2'd1;
    if (phase_ctr < regs[mfts_pkg::CFG_BOUND2]) return 2'd2;
    return 2'd3;
  endfunction

  // scheduling point, returns 1 when the re-enqueue was refused
  function automatic bit dispatch(bit requeue);
    logic [LVL_W-1:0] base;
    logic [LVL_W-1:0] lv;
    if (!cpu_idle) begin
      if (ticks == deadline && prio[cur_tid] != 2'(LEVELS - 1))
        prio[cur_tid] = prio[cur_tid] + 1'b1;
      if (requeue && !ready_push(32'(prio[cur_tid]), cur_tid)) return 1'b1;
    end
    base      = slice_for_phase();
    start_lvl = base;
    deadline  = ticks + TICK_W'(regs[mfts_pkg::CFG_QUANTUM0 + base]);
    for (int i = 0; i < LEVELS; i++) begin
      lv = base + LVL_W'(i);
      if (depth_q[lv] != 0) begin
        cur_tid  = ready_pop(32'(lv));
        cpu_idle = 1'b0;
        return 1'b0;
      end
    end
    cpu_idle = 1'b1;
    return 1'b0;
  endfunction

  // expected result of one event, advancing the predicted state
  function automatic sched_result_t predict_schedule(sched_event_t ev);
    sched_result_t     r;
    bit                was_idle;
    logic [TID_W-1:0]  was_tid;
    bit                refused;
    logic [TICK_W-1:0] elapsed;
    was_idle = cpu_idle;
    was_tid  = cur_tid;
    refused  = 1'b0;
    case (ev.kind)
      mfts_pkg::KIND_TICK: begin
        ticks     = ticks + 1'b1;
        phase_ctr = phase_ctr + 1'b1;
        if (phase_ctr >= regs[mfts_pkg::CFG_PERIOD]) phase_ctr = '0;
        elapsed = ticks - deadline;
        if (!elapsed[TICK_W-1]) refused = dispatch(1'b1);
      end
      mfts_pkg::KIND_START: begin
        if (ev.fresh) prio[ev.tid] = '0;
        refused = !ready_push(32'(prio[ev.tid]), ev.tid);
      end
      mfts_pkg::KIND_YIELD: refused = dispatch(1'b1);
      mfts_pkg::KIND_BLOCK, mfts_pkg::KIND_EXIT: refused = dispatch(1'b0);
      default: ;
    endcase
    if (was_idle != cpu_idle) r.switched = 1'b1;
    else r.switched = !cpu_idle && (was_tid != cur_tid);
    r.running_id = cpu_idle ? '0 : cur_tid;
    r.idle       = cpu_idle;
    r.level      = start_lvl;
    r.full       = refused;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  // predictor update and result check at the rising edge
  always @(posedge clk_i) begin
    sched_result_t want;
    in_taken  <= in_valid && !in_stall;
    out_taken <= out_valid && !out_stall;
    if (rst_ni) begin
      if (cfg_we) regs[cfg_idx] = cfg_wdata;
      if (in_valid && !in_stall) expected_results.push_back(predict_schedule(cur_event));
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_results.size() == 0) begin
          $error("result with no item pending: running_id %0d", out_running_id);
          n_errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("running_id", 32'(want.running_id), 32'(out_running_id));
          check_field("idle_running", 32'(want.idle), 32'(out_idle_running));
          check_field("switched", 32'(want.switched), 32'(out_switched));
          check_field("slice_level", 32'(want.level), 32'(out_slice_level));
          check_field("queue_full", 32'(want.full), 32'(out_queue_full));
          n_refused  += 32'(want.full);
          n_switches += 32'(want.switched);
        end
      end
    end
  end

  // item driver and result stall, both changing at the falling edge
  always @(negedge clk_i) begin
    if (!in_valid || in_taken) begin
      if (send_wait > 0) begin
        in_valid <= 1'b0;
        send_wait--;
      end else if (pending_events.size() != 0) begin
        cur_event = pending_events.pop_front();
        in_kind  <= cur_event.kind;
        in_tid   <= cur_event.tid;
        in_fresh <= cur_event.fresh;
        in_valid <= 1'b1;
        if (sent_count % 32 == 0) calm_send = ($urandom_range(0, 3) == 0);
        sent_count++;
        send_wait = calm_send ? 0 : $urandom_range(0, MAX_WAIT);
      end else begin
        in_valid <= 1'b0;
      end
    end
    if (out_taken) begin
      if (recv_count % 32 == 0) calm_recv = ($urandom_range(0, 3) == 0);
      recv_count++;
      recv_wait = calm_recv ? 0 : $urandom_range(0, MAX_WAIT);
    end
    if (recv_wait > 0) begin
      out_stall <= 1'b1;
      recv_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic program_regs(reg_set_t vals);
    for (int i = 0; i < NUM_CFG; i++) write_reg(CFG_IDX_W'(i), vals[i]);
    n_settings++;
  endtask

  // wait until every item is sent and every result is back
  task automatic settle();
    while (pending_events.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic sched_event_t make_event(mfts_pkg::kind_e kind, int unsigned tid, bit fresh);
    sched_event_t ev;
    ev.kind  = kind;
    ev.tid   = TID_W'(tid);
    ev.fresh = fresh;
    return ev;
  endfunction

  function automatic sched_event_t random_event();
    int unsigned     roll;
    mfts_pkg::kind_e kind;
    roll = $urandom_range(0, 99);
    if (roll < 30) kind = mfts_pkg::KIND_TICK;
    else if (roll < 55) kind = mfts_pkg::KIND_START;
    else if (roll < 70) kind = mfts_pkg::KIND_YIELD;
    else if (roll < 85) kind = mfts_pkg::KIND_BLOCK;
    else kind = mfts_pkg::KIND_EXIT;
    return make_event(kind, $urandom_range(0, NTHR - 1), 1'($urandom_range(0, 1)));
  endfunction

  // random traffic, now and then a burst of fresh starts that overfills level 0
  task automatic add_random(int unsigned count);
    int unsigned k;
    k = 0;
    while (k < count) begin
      if ($urandom_range(0, 59) == 0 && k + BURST_LEN <= count) begin
        for (int b = 0; b < BURST_LEN; b++)
          pending_events.push_back(make_event(mfts_pkg::KIND_START,
                                              $urandom_range(0, NTHR - 1), 1'b1));
        k += BURST_LEN;
      end else begin
        pending_events.push_back(random_event());
        k++;
      end
    end
  endtask

  // quanta mostly short so that ticks expire often, bounds and period anywhere
  function automatic reg_set_t random_regs();
    reg_set_t vals;
    for (int q = 0; q < LEVELS; q++)
      vals[mfts_pkg::CFG_QUANTUM0 + q] = ($urandom_range(0, 3) == 0)
                                         ? CFG_W'($urandom_range(1, 255))
                                         : CFG_W'($urandom_range(1, 6));
    vals[mfts_pkg::CFG_BOUND0] = CFG_W'($urandom_range(0, 255));
    vals[mfts_pkg::CFG_BOUND1] = CFG_W'($urandom_range(0, 255));
    vals[mfts_pkg::CFG_BOUND2] = CFG_W'($urandom_range(0, 255));
    vals[mfts_pkg::CFG_PERIOD] = ($urandom_range(0, 1) == 0) ? CFG_W'($urandom_range(1, 20))
                                                             : CFG_W'($urandom_range(1, 255));
    return vals;
  endfunction

  // stimulus sequence
  initial begin
    reg_set_t vals;
    reset_predictor();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset values written back explicitly, then the directed part
    for (int i = 0; i < NUM_CFG; i++) vals[i] = mfts_pkg::CFG_RESET[i];
    program_regs(vals);
    // tick while idle: idle to idle
    pending_events.push_back(make_event(mfts_pkg::KIND_TICK, 0, 1'b0));
    // fill level 0 with every thread id
    for (int t = 0; t < NTHR; t++)
      pending_events.push_back(make_event(mfts_pkg::KIND_START, t, 1'b1));
    // start refused on a full level
    pending_events.push_back(make_event(mfts_pkg::KIND_START, NTHR - 1, 1'b0));
    // leave idle, refill, then a yield whose re-enqueue is refused
    pending_events.push_back(make_event(mfts_pkg::KIND_YIELD, 0, 1'b0));
    pending_events.push_back(make_event(mfts_pkg::KIND_START, 9, 1'b1));
    pending_events.push_back(make_event(mfts_pkg::KIND_YIELD, 0, 1'b0));
    // expiry tick demotes the running thread
    pending_events.push_back(make_event(mfts_pkg::KIND_TICK, 0, 1'b0));
    pending_events.push_back(make_event(mfts_pkg::KIND_BLOCK, 0, 1'b0));
    pending_events.push_back(make_event(mfts_pkg::KIND_EXIT, 0, 1'b0));
    add_random(100);
    settle();

    // shortest quanta, level 0 always first
    for (int q = 0; q < LEVELS; q++) vals[mfts_pkg::CFG_QUANTUM0 + q] = 8'd1;
    vals[mfts_pkg::CFG_BOUND0] = 8'd255;
    vals[mfts_pkg::CFG_BOUND1] = 8'd255;
    vals[mfts_pkg::CFG_BOUND2] = 8'd255;
    vals[mfts_pkg::CFG_PERIOD] = 8'd255;
    program_regs(vals);
    add_random(90);
    settle();

    // longest quanta, phase stuck at zero, level 3 always first
    for (int q = 0; q < LEVELS; q++) vals[mfts_pkg::CFG_QUANTUM0 + q] = 8'd255;
    vals[mfts_pkg::CFG_BOUND0] = 8'd0;
    vals[mfts_pkg::CFG_BOUND1] = 8'd0;
    vals[mfts_pkg::CFG_BOUND2] = 8'd0;
    vals[mfts_pkg::CFG_PERIOD] = 8'd1;
    program_regs(vals);
    add_random(90);
    settle();

    // random register settings
    for (int p = 0; p < 3; p++) begin
      program_regs(random_regs());
      add_random(90);
      settle();
    end

    $display("run covered %0d events over %0d register settings", n_results, n_settings);
    $display("with %0d refused enqueues and %0d thread switches", n_refused, n_switches);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
